### hw/rtl/pts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic task tick scheduler package
// Shared types and constants for the front end, the op queue and the back end.
// ----------------------------------------------------------------------------
package pts_pkg;

   // Default table size.
   localparam int NUM_SLOTS_DEF = 8;

   // Most due results that one tick may produce.
   localparam int MAX_RESULTS = 8;

   // Field widths.
   localparam int PERIOD_W = 16;
   localparam int SLOT_W   = 3;

   // Depth of the queue between front and back end.
   localparam int QUEUE_DEPTH = 2;

   // Request command codes.
   localparam logic CMD_REGISTER = 1'b0;
   localparam logic CMD_TICK     = 1'b1;

   // Response kind codes.
   localparam logic KIND_REGISTER = 1'b0;
   localparam logic KIND_DUE      = 1'b1;

   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [PERIOD_W-1:0] period_type;

   // Classified request as it travels from front to back end.
   typedef struct packed {
      logic       is_tick;
      logic       accepted;
      logic       active;
      period_type period;
   } op_type;

   // One response item.
   typedef struct packed {
      logic     kind;
      slot_type slot;
      logic     accepted;
      logic     last;
   } rsp_type;

   // Back end sequencer states.
   typedef enum logic {
      BK_IDLE,
      BK_WALK
   } back_state_type;

endpackage
`default_nettype wire

### hw/rtl/pts_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts requests, tracks the fill count and assigns slots to registrations.
// ----------------------------------------------------------------------------
module pts_front #(
   parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEF,
   parameter int IDX_W     = 3,
   parameter int FILL_W    = 4
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire                      req_cmd,
   input  wire pts_pkg::period_type req_period,
   input  wire                      req_task_active,
   input  wire                      q_full,
   output logic                     q_push,
   output pts_pkg::op_type          q_op,
   output logic [IDX_W-1:0]         q_slot
);

   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              room;

   // A request is taken whenever the queue has space.
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign room      = (fill_ff != FILL_W'(NUM_SLOTS));

   // Classify the request and pick the next free slot.
   always_comb begin
      q_op.is_tick  = (req_cmd == pts_pkg::CMD_TICK);
      q_op.accepted = room;
      q_op.active   = req_task_active;
      q_op.period   = req_period;
      q_slot        = room ? fill_ff[IDX_W-1:0] : '0;
      fill_in       = fill_ff;
      if (q_push && (req_cmd == pts_pkg::CMD_REGISTER) && room) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   // Fill count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/pts_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler op queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module pts_queue #(
   parameter int WIDTH = 20
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire [WIDTH-1:0]  push_data,
   output logic             full,
   input  wire              pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = pts_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/pts_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler back end
// Executes registrations, drives the responses and walks the slot table on
// each tick, one slot a cycle unless output stalls, in two read/update stages.
// ----------------------------------------------------------------------------
module pts_back #(
   parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEF,
   parameter int IDX_W     = 3,
   parameter int FILL_W    = 4
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  q_valid,
   input  wire pts_pkg::op_type q_op,
   input  wire [IDX_W-1:0]      q_slot,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output pts_pkg::rsp_type     rsp_data
);

   localparam int DUE_W = $clog2(pts_pkg::MAX_RESULTS + 1);

   // Slot table storage.
   pts_pkg::period_type period_mem [NUM_SLOTS];
   pts_pkg::period_type count_mem  [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] active_ff;
   logic [NUM_SLOTS-1:0] active_in;

   // Sequencer and walk pipeline.
   pts_pkg::back_state_type state_ff;
   pts_pkg::back_state_type state_in;
   logic [FILL_W-1:0]   issue_ff;
   logic [FILL_W-1:0]   issue_in;
   logic [IDX_W-1:0]    rd_idx;
   logic                rd_en;
   logic                s1_vld_ff;
   logic                s1_vld_in;
   logic [IDX_W-1:0]    s1_idx_ff;
   logic [IDX_W-1:0]    s1_idx_in;
   logic                s1_act_ff;
   logic                s1_act_in;
   pts_pkg::period_type period_q_ff;
   pts_pkg::period_type count_q_ff;

   // Pending due result, held until it is known whether it is the last one.
   logic                pend_vld_ff;
   logic                pend_vld_in;
   pts_pkg::slot_type   pend_slot_ff;
   pts_pkg::slot_type   pend_slot_in;
   logic [DUE_W-1:0]    due_num_ff;
   logic [DUE_W-1:0]    due_num_in;

   // Output register.
   logic                out_vld_ff;
   logic                out_vld_in;
   pts_pkg::rsp_type    out_ff;
   pts_pkg::rsp_type    out_in;

   // Memory write port.
   logic                per_we;
   logic                cnt_we;
   logic [IDX_W-1:0]    wr_idx;
   pts_pkg::period_type cnt_wdata;

   // Update-stage datapath.
   pts_pkg::period_type new_cnt;
   logic                take;
   logic                need_push;
   logic                can_push;
   logic                walk_done;

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;
   assign rd_idx    = issue_ff[IDX_W-1:0];
   assign can_push  = !out_vld_ff || !rsp_stall;
   assign new_cnt   = count_q_ff + pts_pkg::period_type'(1);
   assign take      = s1_vld_ff && s1_act_ff && (new_cnt >= period_q_ff)
                      && (due_num_ff < DUE_W'(pts_pkg::MAX_RESULTS));
   assign need_push = take && pend_vld_ff;
   assign walk_done = (issue_ff == FILL_W'(NUM_SLOTS)) && !s1_vld_ff;

   // Next state, walk control and response generation.
   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      rd_en        = 1'b0;
      s1_vld_in    = s1_vld_ff;
      s1_idx_in    = s1_idx_ff;
      s1_act_in    = s1_act_ff;
      pend_vld_in  = pend_vld_ff;
      pend_slot_in = pend_slot_ff;
      due_num_in   = due_num_ff;
      active_in    = active_ff;
      per_we       = 1'b0;
      cnt_we       = 1'b0;
      wr_idx       = s1_idx_ff;
      cnt_wdata    = new_cnt;
      q_pop        = 1'b0;
      out_vld_in   = out_vld_ff && rsp_stall;
      out_in       = out_ff;

      case (state_ff)
         pts_pkg::BK_IDLE: begin
            if (q_valid) begin
               if (!q_op.is_tick) begin
                  // Registration: store the task if accepted and answer once the output is free.
                  if (can_push) begin
                     out_vld_in      = 1'b1;
                     out_in.kind     = pts_pkg::KIND_REGISTER;
                     out_in.slot     = pts_pkg::slot_type'(q_slot);
                     out_in.accepted = q_op.accepted;
                     out_in.last     = 1'b1;
                     if (q_op.accepted) begin
                        per_we            = 1'b1;
                        cnt_we            = 1'b1;
                        wr_idx            = q_slot;
                        cnt_wdata         = '0;
                        active_in[q_slot] = q_op.active;
                     end
                     q_pop = 1'b1;
                  end
               end else begin
                  // Tick: start a fresh walk of the table.
                  state_in    = pts_pkg::BK_WALK;
                  issue_in    = '0;
                  s1_vld_in   = 1'b0;
                  pend_vld_in = 1'b0;
                  due_num_in  = '0;
               end
            end
         end

         pts_pkg::BK_WALK: begin
            if (walk_done) begin
               // Release the held result as the last one, then finish.
               if (pend_vld_ff) begin
                  if (can_push) begin
                     out_vld_in      = 1'b1;
                     out_in.kind     = pts_pkg::KIND_DUE;
                     out_in.slot     = pend_slot_ff;
                     out_in.accepted = 1'b0;
                     out_in.last     = 1'b1;
                     pend_vld_in     = 1'b0;
                     state_in        = pts_pkg::BK_IDLE;
                     q_pop           = 1'b1;
                  end
               end else begin
                  state_in = pts_pkg::BK_IDLE;
                  q_pop    = 1'b1;
               end
            end else if (!(need_push && !can_push)) begin
               // Update stage: advance the counter of the slot held in the read stage.
               if (s1_vld_ff && s1_act_ff) begin
                  cnt_we    = 1'b1;
                  wr_idx    = s1_idx_ff;
                  cnt_wdata = (new_cnt >= period_q_ff) ? '0 : new_cnt;
               end
               if (take) begin
                  if (pend_vld_ff) begin
                     out_vld_in      = 1'b1;
                     out_in.kind     = pts_pkg::KIND_DUE;
                     out_in.slot     = pend_slot_ff;
                     out_in.accepted = 1'b0;
                     out_in.last     = 1'b0;
                  end
                  pend_vld_in  = 1'b1;
                  pend_slot_in = pts_pkg::slot_type'(s1_idx_ff);
                  due_num_in   = due_num_ff + DUE_W'(1);
               end
               // Read stage: issue the next slot.
               if (issue_ff != FILL_W'(NUM_SLOTS)) begin
                  rd_en     = 1'b1;
                  s1_vld_in = 1'b1;
                  s1_idx_in = rd_idx;
                  s1_act_in = active_ff[rd_idx];
                  issue_in  = issue_ff + FILL_W'(1);
               end else begin
                  s1_vld_in = 1'b0;
               end
            end
         end

         default: begin
            state_in = pts_pkg::BK_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pts_pkg::BK_IDLE;
         active_ff   <= '0;
         s1_vld_ff   <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         issue_ff    <= '0;
         due_num_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         active_ff   <= active_in;
         s1_vld_ff   <= s1_vld_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
         issue_ff    <= issue_in;
         due_num_ff  <= due_num_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_idx_ff    <= s1_idx_in;
      s1_act_ff    <= s1_act_in;
      pend_slot_ff <= pend_slot_in;
      out_ff       <= out_in;
   end

   // Period and counter memories: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (per_we) begin
         period_mem[wr_idx] <= q_op.period;
      end
      if (cnt_we) begin
         count_mem[wr_idx] <= cnt_wdata;
      end
      if (rd_en) begin
         period_q_ff <= period_mem[rd_idx];
         count_q_ff  <= count_mem[rd_idx];
      end
   end

endmodule
`default_nettype wire

### hw/rtl/periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// A register request is answered through the op queue and the output register.
// A tick holds the back end for its whole walk, which reads one slot a cycle
// unless the output stalls, through the single read port of the period and
// counter memories. A due result waits until the walk finds the next due slot,
// and the last one leaves as the walk ends. Requests queue up while the back
// end is busy. Synchronous reset clears all active marks, fill count and queue.
// ----------------------------------------------------------------------------
// Periodic task tick scheduler
// Slot table of periodic tasks: registration fills slots in order, each tick
// advances the active counters and reports the slots that became due.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler #(
   parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire                      req_cmd,
   input  wire pts_pkg::period_type req_period,
   input  wire                      req_task_active,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic                     rsp_kind,
   output pts_pkg::slot_type        rsp_slot,
   output logic                     rsp_accepted,
   output logic                     rsp_last
);

   localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int FILL_W = $clog2(NUM_SLOTS + 1);
   localparam int Q_W    = $bits(pts_pkg::op_type) + IDX_W;

   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_valid;
   pts_pkg::op_type     fr_op;
   logic [IDX_W-1:0]    fr_slot;
   pts_pkg::op_type     bk_op;
   logic [IDX_W-1:0]    bk_slot;
   logic [Q_W-1:0]      q_wdata;
   logic [Q_W-1:0]      q_rdata;
   pts_pkg::rsp_type    rsp_data;

   assign q_wdata = {fr_slot, fr_op};
   assign {bk_slot, bk_op} = q_rdata;

   assign rsp_kind     = rsp_data.kind;
   assign rsp_slot     = rsp_data.slot;
   assign rsp_accepted = rsp_data.accepted;
   assign rsp_last     = rsp_data.last;

   // Front end: accept and classify requests.
   pts_front #(
      .NUM_SLOTS (NUM_SLOTS),
      .IDX_W     (IDX_W),
      .FILL_W    (FILL_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_period      (req_period),
      .req_task_active (req_task_active),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_op            (fr_op),
      .q_slot          (fr_slot)
   );

   // Op queue between the two halves.
   pts_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_rdata)
   );

   // Back end: execute ops and produce responses.
   pts_back #(
      .NUM_SLOTS (NUM_SLOTS),
      .IDX_W     (IDX_W),
      .FILL_W    (FILL_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_op      (bk_op),
      .q_slot    (bk_slot),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### tb/sv/tb_periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the periodic task tick scheduler
// Fills the slot table in order with active and inert tasks of short, zero
// and maximal periods, overflows it, then streams mostly tick requests with
// refused registrations mixed in. A slot table predictor in a scoreboard
// class checks every response in order while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_periodic_task_tick_scheduler;
   import pts_pkg::*;

   localparam int SLOTS      = NUM_SLOTS_DEF;
   localparam int RAND_ITEMS = 270;

   // Slot table predictor and response checker.
   class sched_scoreboard;
      period_type  period_tbl[SLOTS];
      period_type  count_tbl[SLOTS];
      bit          active_tbl[SLOTS];
      int unsigned filled;
      rsp_type     pending_answers[$];
      int          errors;
      int          n_registered;
      int          n_refused;
      int          n_ticks;
      int          n_due;

      function new();
         filled       = 0;
         errors       = 0;
         n_registered = 0;
         n_refused    = 0;
         n_ticks      = 0;
         n_due        = 0;
         foreach (active_tbl[i]) active_tbl[i] = 1'b0;
      endfunction

      function int pending();
         return pending_answers.size();
      endfunction

      task report_mismatch(input string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // Work out the responses that one accepted request causes.
      function void note_request(input logic cmd, input period_type period,
                                 input logic act);
         rsp_type answer;
         rsp_type due_list[$];
         if (cmd == CMD_REGISTER) begin
            answer.kind = KIND_REGISTER;
            answer.last = 1'b1;
            if (filled < SLOTS) begin
               period_tbl[filled] = period;
               count_tbl[filled]  = '0;
               active_tbl[filled] = act;
               answer.slot        = slot_type'(filled);
               answer.accepted    = 1'b1;
               filled++;
               n_registered++;
            end else begin
               answer.slot     = '0;
               answer.accepted = 1'b0;
               n_refused++;
            end
            pending_answers.push_back(answer);
         end else begin
            n_ticks++;
            for (int i = 0; i < SLOTS; i++) begin
               if (active_tbl[i]) begin
                  count_tbl[i] = count_tbl[i] + 1'b1;
                  if (count_tbl[i] >= period_tbl[i]) begin
                     count_tbl[i] = '0;
                     if (due_list.size() < MAX_RESULTS) begin
                        answer.kind     = KIND_DUE;
                        answer.slot     = slot_type'(i);
                        answer.accepted = 1'b0;
                        answer.last     = 1'b0;
                        due_list.push_back(answer);
                     end
                  end
               end
            end
            if (due_list.size() > 0) due_list[due_list.size()-1].last = 1'b1;
            n_due += due_list.size();
            foreach (due_list[k]) pending_answers.push_back(due_list[k]);
         end
      endfunction

      // Compare one accepted response against the oldest pending answer.
      task check_response(input logic kind, input slot_type slot,
                          input logic accepted, input logic last);
         rsp_type want;
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("response kind=%0d slot=%0d with nothing pending",
                                      kind, slot));
         end else begin
            want = pending_answers.pop_front();
            if (kind !== want.kind)
               report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
            if (slot !== want.slot)
               report_mismatch($sformatf("slot %0d, want %0d", slot, want.slot));
            if (accepted !== want.accepted)
               report_mismatch($sformatf("accepted %0d, want %0d (slot %0d)",
                                         accepted, want.accepted, want.slot));
            if (last !== want.last)
               report_mismatch($sformatf("last %0d, want %0d (slot %0d)",
                                         last, want.last, want.slot));
         end
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_cmd;
   period_type req_period;
   logic       req_task_active;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_kind;
   slot_type   rsp_slot;
   logic       rsp_accepted;
   logic       rsp_last;

   // Set during the stretch of the run where neither side idles.
   bit calm;

   sched_scoreboard sb;

   periodic_task_tick_scheduler u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_period      (req_period),
      .req_task_active (req_task_active),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_slot        (rsp_slot),
      .rsp_accepted    (rsp_accepted),
      .rsp_last        (rsp_last)
   );

   // Clock with a 4 ns period.
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Check accepted responses and stall the response channel at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_kind, rsp_slot, rsp_accepted, rsp_last);
      rsp_stall <= !calm && ($urandom_range(99) < 8);
   end

   // Present one request and hold it until the block takes it.
   task automatic send_request(input logic cmd, input period_type period,
                               input logic act);
      if (!calm && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 40);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_period      <= period;
      req_task_active <= act;
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, period, act);
   endtask

   // Tick request with noise on the unused fields.
   task automatic send_tick();
      send_request(CMD_TICK, period_type'($urandom), 1'($urandom));
   endtask

   // Hold off the sender until every pending response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Generous limit on the whole run.
   initial begin
      #1_000_000;
      $display("tb_periodic_task_tick_scheduler: errors");
      $finish;
   end

   // Reset, directed requests, random requests, drain and verdict.
   initial begin
      int wait_cycles;
      sb              = new();
      calm            = 1'b0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_cmd         <= CMD_TICK;
      req_period      <= '0;
      req_task_active <= 1'b0;
      rsp_stall       <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Tick on an empty table: counters idle and nothing is due.
      send_tick();
      // Period zero is due on every tick.
      send_request(CMD_REGISTER, 16'h0000, 1'b1);
      send_tick();
      send_request(CMD_REGISTER, 16'h0001, 1'b1);
      send_request(CMD_REGISTER, 16'hFFFF, 1'b1);
      // An inert slot still takes its place in the table.
      send_request(CMD_REGISTER, 16'h0001, 1'b0);
      send_tick();
      send_request(CMD_REGISTER, 16'h0002, 1'b1);
      send_request(CMD_REGISTER, 16'h0003, 1'b1);
      send_request(CMD_REGISTER, 16'h0004, 1'b1);
      send_request(CMD_REGISTER, 16'h0006, 1'b1);
      // The table is full now, so both of these are refused.
      send_request(CMD_REGISTER, 16'hFFFF, 1'b1);
      send_request(CMD_REGISTER, 16'h0000, 1'b0);
      repeat (6) send_tick();
      drain_responses();

      // Mostly ticks, with refused registrations as noise.
      for (int n = 0; n < RAND_ITEMS; n++) begin
         calm = (n >= 100 && n < 160);
         if (n == 200) drain_responses();
         if ($urandom_range(99) < 15)
            send_request(CMD_REGISTER, period_type'($urandom), 1'($urandom));
         else
            send_tick();
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // Let every pending response arrive, then allow for the tick walk.
      wait_cycles = 0;
      while (sb.pending() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (SLOTS + 8) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending()));

      $display("Covered %0d registrations and %0d refused ones on a %0d slot table,",
               sb.n_registered, sb.n_refused, SLOTS);
      $display("and %0d ticks that made %0d slots due.", sb.n_ticks, sb.n_due);
      if (sb.errors == 0)
         $display("tb_periodic_task_tick_scheduler: clean");
      else
         $display("tb_periodic_task_tick_scheduler: errors");
      $finish;
   end

endmodule

### files.f
hw/rtl/pts_pkg.sv
hw/rtl/pts_front.sv
hw/rtl/pts_queue.sv
hw/rtl/pts_back.sv
hw/rtl/periodic_task_tick_scheduler.sv
tb/sv/tb_periodic_task_tick_scheduler.sv
